### hdl/tcce_pkg.sv
// shared types and constants of the text console cursor engine
// payload structs, command and character codes, sequencer states
// no dependencies
package tcce_pkg;

  // default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths of the channels
  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

  // character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  read_index;
  } item_t;

  // result beat
  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [IDX_W-1:0]  text_length;
    logic [CHAR_W-1:0] cell_char;
    logic              scrolled;
  } result_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RIGHT_CHK,
    ST_READ_CHK,
    ST_SCROLL,
    ST_HW,
    ST_DONE
  } state_t;

endpackage

### hdl/tcce_chan_if.sv
// valid/ready channel carrying one payload beat
// payload type given as a parameter, normally a struct from tcce_pkg
interface tcce_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/tcce_cell_ram.sv
// character cell memory: one write port, one read port with registered data
// depends on nothing but its parameters
module tcce_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int AW     = 11,
  parameter int DW     = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/text_console_cursor_engine_top.sv
// text console cursor engine: cell memory, cursor, text length and sequencer
// depends on tcce_pkg, tcce_chan_if and tcce_cell_ram
//
// Usage. Commands arrive on the item channel (cmd, char_code, read_index) and
// each gives exactly one beat on the result channel (cursor_index,
// text_length, cell_char, scrolled). The screen is ROWS by COLUMNS cells held
// in one synchronous RAM organised as a ring of rows: a scroll moves the ring
// base one row and blanks only the row that wraps round.
// Sequence. One command is in work at a time. A plain command passes through
// the states EXEC, HW and DONE to its result; a right step or an in-range read
// adds a check state for the RAM read. A step back across a line start scans the
// previous row right to left, reading and then checking each cell; a scroll
// blanks one row at one cell a cycle.
// Reset. rst is synchronous. After it the block walks all ROWS*COLUMNS cells of
// the RAM (2000 at the defaults) writing spaces, one cell a cycle, and holds
// item.ready low meanwhile. Cursor and length start at zero.
// Stalls. The result sits in an output register; the next item may be
// accepted and worked on while it waits, and that item then holds in its
// final state until the register is free.
module text_console_cursor_engine_top #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst,
  tcce_chan_if.sink   item,
  tcce_chan_if.source result
);
  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  // state registers
  state_t        state, state_next;
  item_t         item_q;
  result_t       res_q;
  logic          out_valid;
  logic [AW-1:0] cur;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] hw;
  logic [AW-1:0] base;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] scan_addr;
  logic [CW-1:0] scan_col;
  logic [CHAR_W-1:0] cell_q;
  logic          scr_q;

  // memory port signals
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;

  // decode and helpers
  logic          accept;
  logic          ld_out;
  logic [AW-1:0] cur_phys;
  logic [AW-1:0] cur_phys_prev;
  logic [AW-1:0] ridx_phys;
  logic          ridx_ok;
  logic          put_bs, put_nl, put_ign, put_chr;
  logic          last_col, last_row, need_scroll;
  logic          right_ok, down_ok;
  logic          back_scan;
  logic [AW-1:0] scroll_end;
  logic          scan_found;
  logic          scan_inc;
  logic [CW-1:0] scan_tcol;

  // logical position to ring address
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] p,
                                            input logic [AW-1:0] b);
    logic [PW-1:0] s;
    s = {1'b0, p} + {1'b0, b};
    if (s >= PW'(CELLS)) begin
      s = s - PW'(CELLS);
    end
    return s[AW-1:0];
  endfunction

  tcce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CHAR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // command decode
  always_comb begin
    accept        = item.valid && item.ready;
    ld_out        = (state == ST_DONE) && (!out_valid || result.ready);
    cur_phys      = to_phys(cur, base);
    cur_phys_prev = (cur_phys == '0) ? AW'(CELLS - 1) : cur_phys - AW'(1);
    ridx_ok       = 32'(item_q.read_index) < CELLS;
    ridx_phys     = to_phys(AW'(item_q.read_index), base);
    put_bs        = item_q.char_code == CH_BS;
    put_nl        = item_q.char_code == CH_NL;
    put_ign       = (item_q.char_code == CH_NUL) || (item_q.char_code == CH_TAB) ||
                    (item_q.char_code == CH_DEL);
    put_chr       = !put_bs && !put_nl && !put_ign;
    last_col      = col == CW'(COLUMNS - 1);
    last_row      = row == RW'(ROWS - 1);
    need_scroll   = last_row && (put_nl || (put_chr && last_col));
    right_ok      = (cur < AW'(CELLS - 1)) && (cur < hw);
    down_ok       = (cur < AW'(CELLS - COLUMNS - 1)) &&
                    (({1'b0, cur} + PW'(COLUMNS)) < {1'b0, hw});
    back_scan     = (cur != '0) && (col == '0);
    scroll_end    = base + AW'(COLUMNS - 1);
  end

  // leftward scan decision on the cell just read
  always_comb begin
    scan_found = 1'b0;
    scan_inc   = 1'b0;
    scan_tcol  = scan_col;
    if (scan_col == CW'(COLUMNS - 1)) begin
      if (rd_data != CH_SP) begin
        scan_found = 1'b1;
      end
    end else if (rd_data == CH_NL) begin
      scan_found = 1'b1;
    end else if (rd_data != CH_SP) begin
      scan_found = 1'b1;
      scan_inc   = 1'b1;
      scan_tcol  = scan_col + CW'(1);
    end
    if (!scan_found && (scan_col == '0)) begin
      scan_found = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_HW;
        unique case (item_q.cmd)
          CMD_PUT: begin
            if (put_bs && back_scan) state_next = ST_SCAN_RD;
            else if (need_scroll)    state_next = ST_SCROLL;
          end
          CMD_LEFT: begin
            if (back_scan) state_next = ST_SCAN_RD;
          end
          CMD_RIGHT: begin
            if (right_ok) state_next = ST_RIGHT_CHK;
          end
          CMD_READ: begin
            if (ridx_ok) state_next = ST_READ_CHK;
          end
          default: state_next = ST_HW;
        endcase
      end
      ST_SCAN_RD:   state_next = ST_SCAN_CHK;
      ST_SCAN_CHK:  state_next = scan_found ? ST_HW : ST_SCAN_RD;
      ST_RIGHT_CHK: state_next = ST_HW;
      ST_READ_CHK:  state_next = ST_HW;
      ST_SCROLL: begin
        if (clr_addr == scroll_end) state_next = ST_HW;
      end
      ST_HW:   state_next = ST_DONE;
      ST_DONE: begin
        if (ld_out) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    item.ready = state == ST_IDLE;
    wr_en      = 1'b0;
    wr_addr    = cur_phys;
    wr_data    = CH_SP;
    rd_addr    = cur_phys;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_EXEC: begin
        if (item_q.cmd == CMD_READ) begin
          rd_addr = ridx_phys;
        end
        if (item_q.cmd == CMD_PUT) begin
          if (put_nl || put_chr) begin
            wr_en   = 1'b1;
            wr_data = item_q.char_code;
          end else if (put_bs && (cur != '0) && (col != '0)) begin
            wr_en   = 1'b1;
            wr_addr = cur_phys - AW'(1);
          end
        end
      end
      ST_SCAN_RD: begin
        rd_addr = scan_addr;
      end
      ST_SCAN_CHK: begin
        if (scan_found && (item_q.cmd == CMD_PUT)) begin
          wr_en   = 1'b1;
          wr_addr = scan_addr + AW'(scan_inc);
        end
      end
      ST_SCROLL: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      default: wr_en = 1'b0;
    endcase
    result.valid   = out_valid;
    result.payload = res_q;
  end

  // datapath and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
      cur       <= '0;
      col       <= '0;
      row       <= '0;
      hw        <= '0;
      base      <= '0;
      clr_addr  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        ST_IDLE: begin
          if (accept) item_q <= item.payload;
        end
        ST_EXEC: begin
          cell_q    <= '0;
          scr_q     <= 1'b0;
          scan_addr <= cur_phys_prev;
          scan_col  <= CW'(COLUMNS - 1);
          case (item_q.cmd)
            CMD_PUT: begin
              if (need_scroll) begin
                // whole screen moves up, cursor to bottom row start
                cur      <= AW'(CELLS - COLUMNS);
                row      <= RW'(ROWS - 1);
                col      <= '0;
                hw       <= (hw >= AW'(COLUMNS)) ? hw - AW'(COLUMNS) : '0;
                clr_addr <= base;
                scr_q    <= 1'b1;
              end else if (put_nl || (put_chr && last_col)) begin
                cur <= AW'(PW'(cur) + PW'(COLUMNS) - PW'(col));
                row <= row + RW'(1);
                col <= '0;
              end else if (put_chr) begin
                cur <= cur + AW'(1);
                col <= col + CW'(1);
              end else if (put_bs && (cur != '0) && (col != '0)) begin
                cur <= cur - AW'(1);
                col <= col - CW'(1);
              end
            end
            CMD_LEFT: begin
              if ((cur != '0) && (col != '0)) begin
                cur <= cur - AW'(1);
                col <= col - CW'(1);
              end
            end
            CMD_UP: begin
              if (row != '0) begin
                cur <= cur - AW'(COLUMNS);
                row <= row - RW'(1);
              end
            end
            CMD_DOWN: begin
              if (down_ok) begin
                cur <= cur + AW'(COLUMNS);
                row <= row + RW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN_CHK: begin
          if (scan_found) begin
            cur <= cur - AW'(COLUMNS) + AW'(scan_tcol);
            row <= row - RW'(1);
            col <= scan_tcol;
          end else begin
            scan_col  <= scan_col - CW'(1);
            scan_addr <= scan_addr - AW'(1);
          end
        end
        ST_RIGHT_CHK: begin
          if (rd_data == CH_NL) begin
            if (last_row) begin
              // no next row: hold at the last cell
              cur <= AW'(CELLS - 1);
              col <= CW'(COLUMNS - 1);
            end else begin
              cur <= AW'(PW'(cur) + PW'(COLUMNS) - PW'(col));
              row <= row + RW'(1);
              col <= '0;
            end
          end else if (last_col) begin
            cur <= cur + AW'(1);
            row <= row + RW'(1);
            col <= '0;
          end else begin
            cur <= cur + AW'(1);
            col <= col + CW'(1);
          end
        end
        ST_READ_CHK: begin
          cell_q <= rd_data;
        end
        ST_SCROLL: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == scroll_end) begin
            base <= (base == AW'(CELLS - COLUMNS)) ? '0 : base + AW'(COLUMNS);
          end
        end
        ST_HW: begin
          if ((item_q.cmd == CMD_PUT) && (cur > hw)) hw <= cur;
        end
        ST_DONE: begin
          if (ld_out) begin
            res_q.cursor_index <= IDX_W'(cur);
            res_q.text_length  <= IDX_W'(hw);
            res_q.cell_char    <= cell_q;
            res_q.scrolled     <= scr_q;
          end
        end
        default: begin
          clr_addr <= clr_addr;
        end
      endcase
      // output register occupancy
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // cursor index, row and column stay consistent
  a_cursor_rc: assert property (@(posedge clk) disable iff (rst)
    32'(cur) == 32'(row) * COLUMNS + 32'(col))
    else $error("cursor index disagrees with row and column");

  // a scroll always leaves the cursor at the bottom row start
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCROLL |-> (col == '0) && (row == RW'(ROWS - 1)))
    else $error("scroll with cursor off the bottom row start");

  // ring base stays on a row boundary inside the memory
  a_base_row: assert property (@(posedge clk) disable iff (rst)
    (32'(base) % COLUMNS == 0) && (32'(base) < CELLS))
    else $error("ring base off a row boundary");

  // memory untouched while idle or holding a result
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) || (state == ST_DONE) |-> !wr_en)
    else $error("cell write outside a command");
`endif

endmodule

### sim/tcce_console_checker.sv
// checker for the text console cursor engine: watches both channels at the clock edge
// keeps its own copy of the screen, cursor and text length and compares every result beat
// depends on tcce_pkg
module tcce_console_checker #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  tcce_pkg::item_t   item_payload,
  input  logic              result_valid,
  input  logic              result_ready,
  input  tcce_pkg::result_t result_payload,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  // console image as the block should hold it
  logic [CHAR_W-1:0] screen [CELLS];
  int unsigned       cursor_at;
  int unsigned       length_mark;

  // views the block still owes, oldest first
  result_t     owed_views [$];
  result_t     want;
  result_t     fresh;
  int unsigned mismatches;

  assign fail_count = mismatches;

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t ns tcce check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [CHAR_W-1:0] cell_of(input int unsigned i);
    return (i < CELLS) ? screen[i] : '0;
  endfunction

  // landing cell of a step back from position p (p above zero)
  function automatic int unsigned back_target(input int unsigned p);
    int unsigned       last_cell;
    int unsigned       row_first;
    int unsigned       j;
    logic [CHAR_W-1:0] c;
    if (p % COLUMNS != 0) return p - 1;
    last_cell = p - 1;
    row_first = last_cell - (last_cell % COLUMNS);
    if (cell_of(last_cell) != CH_SP) return last_cell;
    // scan the previous row right to left
    j = last_cell + 1;
    while (j > row_first) begin
      j--;
      c = cell_of(j);
      if (c == CH_NL) return j;
      if (c != CH_SP) return j + 1;
    end
    return row_first;
  endfunction

  // move every row up by one, blank the bottom row, put the cursor at its start and shorten the length by a row
  task automatic scroll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = CH_SP;
    cursor_at   = CELLS - COLUMNS;
    length_mark = (length_mark >= COLUMNS) ? length_mark - COLUMNS : 0;
  endtask

  // apply one command to the console image and give the view it leaves
  task automatic advance_console(input item_t it, output result_t view);
    logic [CHAR_W-1:0] rd;
    logic              scr;
    rd  = '0;
    scr = 1'b0;
    case (it.cmd)
      CMD_PUT: begin
        if (it.char_code == CH_BS) begin
          if (cursor_at > 0) begin
            cursor_at = back_target(cursor_at);
            if (cursor_at < CELLS) screen[cursor_at] = CH_SP;
          end
        end else if (it.char_code == CH_NL) begin
          if (cursor_at < CELLS) screen[cursor_at] = CH_NL;
          cursor_at = (cursor_at / COLUMNS + 1) * COLUMNS;
          if (cursor_at >= CELLS) begin
            scroll_up();
            scr = 1'b1;
          end
        end else if (it.char_code != CH_NUL && it.char_code != CH_TAB &&
                     it.char_code != CH_DEL) begin
          if (cursor_at < CELLS) screen[cursor_at] = it.char_code;
          cursor_at++;
          if (cursor_at >= CELLS) begin
            scroll_up();
            scr = 1'b1;
          end
        end
        if (cursor_at > length_mark) length_mark = cursor_at;
      end
      CMD_LEFT: begin
        if (cursor_at > 0) cursor_at = back_target(cursor_at);
      end
      CMD_RIGHT: begin
        if (cursor_at < CELLS - 1 && cursor_at < length_mark) begin
          if (cell_of(cursor_at) == CH_NL) cursor_at += COLUMNS - (cursor_at % COLUMNS);
          else cursor_at++;
          if (cursor_at >= CELLS) cursor_at = CELLS - 1;
        end
      end
      CMD_UP: begin
        if (cursor_at > COLUMNS - 1) cursor_at -= COLUMNS;
      end
      CMD_DOWN: begin
        if (cursor_at < CELLS - COLUMNS - 1 && cursor_at + COLUMNS < length_mark)
          cursor_at += COLUMNS;
      end
      CMD_READ: begin
        rd = cell_of(it.read_index);
      end
      default: begin
      end
    endcase
    view.cursor_index = cursor_at[IDX_W-1:0];
    view.text_length  = length_mark[IDX_W-1:0];
    view.cell_char    = rd;
    view.scrolled     = scr;
  endtask

  initial mismatches = 0;

  // result beats are matched before the command of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = CH_SP;
      cursor_at   = 0;
      length_mark = 0;
      owed_views.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (owed_views.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: cursor %0d length %0d",
                                    result_payload.cursor_index, result_payload.text_length));
        end else begin
          want = owed_views.pop_front();
          if (result_payload.cursor_index != want.cursor_index)
            report_mismatch($sformatf("cursor_index got %0d expected %0d",
                                      result_payload.cursor_index, want.cursor_index));
          if (result_payload.text_length != want.text_length)
            report_mismatch($sformatf("text_length got %0d expected %0d",
                                      result_payload.text_length, want.text_length));
          if (result_payload.cell_char != want.cell_char)
            report_mismatch($sformatf("cell_char got 0x%02h expected 0x%02h",
                                      result_payload.cell_char, want.cell_char));
          if (result_payload.scrolled != want.scrolled)
            report_mismatch($sformatf("scrolled got %0b expected %0b",
                                      result_payload.scrolled, want.scrolled));
        end
      end
      if (item_valid && item_ready) begin
        advance_console(item_payload, fresh);
        owed_views.push_back(fresh);
      end
    end
    pending <= $unsigned(owed_views.size());
  end

endmodule

### sim/tb_text_console_cursor_engine_top.sv
// testbench top for the text console cursor engine: clock, reset, command stimulus, verdict
// depends on tcce_pkg, tcce_chan_if, text_console_cursor_engine_top and tcce_console_checker
module tb_text_console_cursor_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  // command codes the block does not use
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  logic clk;
  logic rst;

  tcce_chan_if #(.payload_t(item_t))   item_if ();
  tcce_chan_if #(.payload_t(result_t)) result_if ();

  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      beats_counted;
  int unsigned      fail_count;
  int unsigned      pending;
  logic [IDX_W-1:0] seen_cursor;

  text_console_cursor_engine_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  tcce_console_checker console_watch (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_if.valid),
    .item_ready     (item_if.ready),
    .item_payload   (item_if.payload),
    .result_valid   (result_if.valid),
    .result_ready   (result_if.ready),
    .result_payload (result_if.payload),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_text_console_cursor_engine_top: FAIL");
    $finish;
  end

  // result side: random back-pressure, last cursor kept to aim reads at fresh text
  initial begin
    result_if.ready <= 1'b0;
    seen_cursor     <= '0;
    forever begin
      @(posedge clk);
      if (result_if.valid && result_if.ready) seen_cursor <= result_if.payload.cursor_index;
      result_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [IDX_W-1:0] any_idx();
    return IDX_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // mostly printable text, some spaces, a few raw bytes
  function automatic logic [CHAR_W-1:0] text_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 84) return CHAR_W'($urandom_range(8'h21, 8'h7E));
    if (pick < 95) return CH_SP;
    return any_char();
  endfunction

  // read address near the cursor most of the time, anywhere otherwise
  function automatic logic [IDX_W-1:0] read_spot();
    int unsigned back;
    if ($urandom_range(0, 9) < 3) return any_idx();
    back = $urandom_range(0, 2 * COLUMNS_DEF);
    return (seen_cursor > back) ? IDX_W'(seen_cursor - back) : '0;
  endfunction

  // drive one command beat and hold it until the block takes it
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    item_t beat;
    beat.cmd        = cmd;
    beat.char_code  = ch;
    beat.read_index = idx;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.payload <= beat;
    item_if.valid   <= 1'b1;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    // ignored codes and spare commands do not count towards the run length
    if (cmd <= CMD_READ &&
        !(cmd == CMD_PUT && (ch == CH_NUL || ch == CH_TAB || ch == CH_DEL)))
      beats_counted++;
  endtask

  // random editing sessions: typing, newlines, rub-outs, cursor moves, reads, noise
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n;
    stop_at = beats_counted + quota;
    while (beats_counted < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = $urandom_range(1, 10);
        repeat (n) send_beat(CMD_PUT, text_char(), any_idx());
      end else if (kind < 39) begin
        // long line, wraps past the row end
        n = $urandom_range(70, 90);
        repeat (n) send_beat(CMD_PUT, text_char(), any_idx());
      end else if (kind < 54) begin
        n = $urandom_range(1, 3);
        repeat (n) send_beat(CMD_PUT, CH_NL, any_idx());
      end else if (kind < 64) begin
        n = $urandom_range(1, 5);
        repeat (n) send_beat(CMD_PUT, CH_BS, any_idx());
      end else if (kind < 79) begin
        n = $urandom_range(1, 4);
        repeat (n) send_beat(CMD_W'($urandom_range(CMD_LEFT, CMD_DOWN)), any_char(),
                             any_idx());
      end else if (kind < 92) begin
        n = $urandom_range(1, 3);
        repeat (n) send_beat(CMD_READ, any_char(), read_spot());
      end else begin
        send_beat(CMD_W'($urandom_range(0, 7)), any_char(), any_idx());
      end
    end
  endtask

  initial begin
    rst             <= 1'b1;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    beats_counted = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of the fields, every command, the step-back rules
    send_beat(CMD_READ, any_char(), '0);
    send_beat(CMD_LEFT, any_char(), any_idx());           // nothing at the first cell
    send_beat(CMD_PUT, CH_BS, any_idx());                 // rub-out at the first cell
    send_beat(CMD_PUT, CH_NUL, any_idx());
    send_beat(CMD_PUT, CH_TAB, any_idx());
    send_beat(CMD_PUT, CH_DEL, any_idx());
    send_beat(CMD_PUT, 8'h41, any_idx());
    send_beat(CMD_PUT, 8'hFF, any_idx());
    send_beat(CMD_PUT, CH_SP, any_idx());
    send_beat(CMD_PUT, CH_NL, any_idx());
    send_beat(CMD_PUT, CH_BS, any_idx());                 // back onto the newline
    send_beat(CMD_PUT, 8'h42, any_idx());
    send_beat(CMD_PUT, CH_NL, any_idx());
    send_beat(CMD_LEFT, any_char(), any_idx());           // onto the newline, kept
    send_beat(CMD_RIGHT, any_char(), any_idx());          // newline jumps to next row
    send_beat(CMD_PUT, 8'h43, any_idx());
    send_beat(CMD_UP, any_char(), any_idx());
    send_beat(CMD_RIGHT, any_char(), any_idx());
    send_beat(CMD_DOWN, any_char(), any_idx());           // blocked by the text length
    send_beat(CMD_UP, any_char(), any_idx());             // top row, stays
    send_beat(CMD_READ, any_char(), 11'd1999);
    send_beat(CMD_READ, any_char(), 11'd2000);            // out of range
    send_beat(CMD_READ, 8'hFF, 11'd2047);
    send_beat(CMD_SPARE6, any_char(), any_idx());
    send_beat(CMD_SPARE7, any_char(), any_idx());

    // random phases with changing back-pressure
    send_idle_pct = 16;
    recv_idle_pct = 62;
    run_random(150);
    send_idle_pct = 62;
    recv_idle_pct = 16;
    run_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(150);

    // drain, then allow for a late stray beat
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * COLUMNS_DEF) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_text_console_cursor_engine_top: PASS");
    end else begin
      $display("tb_text_console_cursor_engine_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tcce_pkg.sv
hdl/tcce_chan_if.sv
hdl/tcce_cell_ram.sv
hdl/text_console_cursor_engine_top.sv
sim/tcce_console_checker.sv
sim/tb_text_console_cursor_engine_top.sv
